@@ rtl/core/rlbe_pkg.sv @@
// Shared types, constants and helpers of the rain line billboard expander.
`timescale 1ns / 1ps
package rlbe_pkg;

   // stage counts of the three arithmetic units
   localparam int OFF_LAT = 33;
   localparam int LIT_LAT = 7;
   localparam int SH_LAT  = 4;

   localparam logic [31:0] LIT_GREEN  = 32'hFF00FF00;
   localparam logic [31:0] UNLIT_RED  = 32'hFFFF0000;
   localparam logic [31:0] RGB_MASK   = 32'h00FFFFFF;
   localparam logic [31:0] ALPHA_FULL = 32'hFF000000;
   localparam logic [15:0] SHOULDER_Q16 = 16'd63570;

   localparam logic [1:0] MODE_PASS  = 2'd0;
   localparam logic [1:0] MODE_LIGHT = 2'd1;
   localparam logic [1:0] MODE_DEBUG = 2'd2;

   typedef enum logic [2:0] {
      CSR_VIEWER_X   = 3'd0,
      CSR_VIEWER_Z   = 3'd1,
      CSR_CAMERA_X   = 3'd2,
      CSR_CAMERA_Z   = 3'd3,
      CSR_LIGHT_X    = 3'd4,
      CSR_LIGHT_Z    = 3'd5,
      CSR_DROP_WIDTH = 3'd6,
      CSR_COLOR_MODE = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic [31:0] top_x;
      logic [31:0] top_y;
      logic [31:0] top_z;
      logic [31:0] top_color;
      logic [31:0] bottom_x;
      logic [31:0] bottom_y;
      logic [31:0] bottom_z;
      logic [31:0] bottom_color;
      logic        final_line;
   } payload_type;

   typedef struct packed {
      payload_type        line;
      logic signed [20:0] ox;
      logic signed [20:0] oz;
      logic signed [33:0] sh;
      logic               lit;
   } emit_in_type;

   function automatic logic [31:0] sat32(input logic signed [33:0] v);
      logic [31:0] r;
      if (v > 34'sh0_7FFF_FFFF) begin
         r = 32'h7FFF_FFFF;
      end else if (v < -34'sh0_8000_0000) begin
         r = 32'h8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

@@ rtl/core/rlbe_delay.sv @@
// Advance-gated delay line that aligns data with the longest unit.
`timescale 1ns / 1ps
module rlbe_delay #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 1
) (
   input  logic             clock,
   input  logic             adv,
   input  logic [WIDTH-1:0] d,
   output logic [WIDTH-1:0] q
);
   logic [WIDTH-1:0] tap_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (adv) begin
         tap_ff[0] <= d;
         for (int i = 1; i < DEPTH; i++) begin
            tap_ff[i] <= tap_ff[i-1];
         end
      end
   end

   assign q = tap_ff[DEPTH-1];
endmodule

@@ rtl/core/rlbe_offset.sv @@
// Camera-facing side offset: normalise, square root and two divisions.
`timescale 1ns / 1ps
module rlbe_offset import rlbe_pkg::*; (
   input  logic               clock,
   input  logic               adv,
   input  logic [31:0]        camera_x,
   input  logic [31:0]        camera_z,
   input  logic [19:0]        drop_width,
   input  logic [31:0]        top_x,
   input  logic [31:0]        top_z,
   output logic signed [20:0] ox,
   output logic signed [20:0] oz
);
   localparam int SQ_STAGES  = 16;
   localparam int DIV_STAGES = 10;

   typedef struct packed {
      logic [30:0] an;
      logic [30:0] zn;
      logic        zero;
      logic        txp;
      logic        tzn;
   } side_type;

   typedef struct packed {
      logic [63:0] x;
      logic [63:0] r;
   } sq_type;

   typedef struct packed {
      logic [52:0] rem;
      logic        qbit;
   } dv_type;

   function automatic sq_type sq_step(input sq_type s, input int j);
      logic [63:0] bitv;
      sq_type o;
      bitv = 64'd1 << (2 * j);
      o = s;
      if (s.x >= s.r + bitv) begin
         o.x = s.x - (s.r + bitv);
         o.r = (s.r >> 1) + bitv;
      end else begin
         o.r = s.r >> 1;
      end
      return o;
   endfunction

   function automatic dv_type dv_step(input logic [52:0] rem, input logic [32:0] den,
                                      input int i);
      logic [52:0] t;
      dv_type o;
      t = {20'd0, den} << i;
      o.qbit = (rem >= t);
      o.rem  = o.qbit ? rem - t : rem;
      return o;
   endfunction

   // stage 1: magnitudes
   logic signed [32:0] tx_c, tz_c;
   logic [32:0] ax1_ff, az1_ff;
   logic        txp1_ff, tzn1_ff;

   assign tx_c = $signed({camera_x[31], camera_x}) - $signed({top_x[31], top_x});
   assign tz_c = $signed({camera_z[31], camera_z}) - $signed({top_z[31], top_z});

   always_ff @(posedge clock) begin
      if (adv) begin
         ax1_ff  <= tx_c[32] ? 33'(-tx_c) : 33'(tx_c);
         az1_ff  <= tz_c[32] ? 33'(-tz_c) : 33'(tz_c);
         txp1_ff <= !tx_c[32] && (tx_c != 33'sd0);
         tzn1_ff <= tz_c[32];
      end
   end

   // stage 2: shift search
   logic [32:0] m_c;
   logic [4:0]  msb_c;
   logic [32:0] ax2_ff, az2_ff;
   logic [4:0]  s2_ff;
   logic        shr2_ff, zero2_ff, txp2_ff, tzn2_ff;

   always_comb begin
      m_c   = (ax1_ff > az1_ff) ? ax1_ff : az1_ff;
      msb_c = 5'd0;
      for (int i = 0; i < 31; i++) begin
         if (m_c[i]) begin
            msb_c = 5'(i);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ax2_ff   <= ax1_ff;
         az2_ff   <= az1_ff;
         s2_ff    <= 5'd30 - msb_c;
         shr2_ff  <= m_c[32] | m_c[31];
         zero2_ff <= (m_c == 33'd0);
         txp2_ff  <= txp1_ff;
         tzn2_ff  <= tzn1_ff;
      end
   end

   // stage 3: apply shift
   side_type side3_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         side3_ff.an   <= shr2_ff ? ax2_ff[31:1] : (ax2_ff[30:0] << s2_ff);
         side3_ff.zn   <= shr2_ff ? az2_ff[31:1] : (az2_ff[30:0] << s2_ff);
         side3_ff.zero <= zero2_ff;
         side3_ff.txp  <= txp2_ff;
         side3_ff.tzn  <= tzn2_ff;
      end
   end

   // stages 4 and 5: squares and their sum
   logic [61:0] sqa4_ff, sqz4_ff;
   side_type    side4_ff, side5_ff;
   logic [63:0] x5_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         sqa4_ff  <= side3_ff.an * side3_ff.an;
         sqz4_ff  <= side3_ff.zn * side3_ff.zn;
         side4_ff <= side3_ff;
         x5_ff    <= {2'd0, sqa4_ff} + {2'd0, sqz4_ff};
         side5_ff <= side4_ff;
      end
   end

   // square root, two result bits a stage
   sq_type   sq_ff   [SQ_STAGES];
   side_type sqs_ff  [SQ_STAGES];
   sq_type   sq_c    [SQ_STAGES];

   always_comb begin
      for (int k = 0; k < SQ_STAGES; k++) begin
         sq_c[k] = (k == 0) ? sq_type'{x: x5_ff, r: 64'd0} : sq_ff[k-1];
         sq_c[k] = sq_step(sq_c[k], 31 - 2 * k);
         sq_c[k] = sq_step(sq_c[k], 30 - 2 * k);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < SQ_STAGES; k++) begin
            sq_ff[k]  <= sq_c[k];
            sqs_ff[k] <= (k == 0) ? side5_ff : sqs_ff[k-1];
         end
      end
   end

   // numerators with rounding term, denominator 2L
   logic [31:0] len_c;
   logic [52:0] nx22_ff, nz22_ff;
   logic [32:0] den22_ff;
   side_type    side22_ff;

   assign len_c = sq_ff[SQ_STAGES-1].r[31:0];

   always_ff @(posedge clock) begin
      if (adv) begin
         nx22_ff   <= 53'(sqs_ff[SQ_STAGES-1].zn * drop_width) + {21'd0, len_c};
         nz22_ff   <= 53'(sqs_ff[SQ_STAGES-1].an * drop_width) + {21'd0, len_c};
         den22_ff  <= {len_c, 1'b0};
         side22_ff <= sqs_ff[SQ_STAGES-1];
      end
   end

   // restoring division, two quotient bits a stage
   logic [52:0] rx_ff [DIV_STAGES];
   logic [52:0] rz_ff [DIV_STAGES];
   logic [19:0] qx_ff [DIV_STAGES];
   logic [19:0] qz_ff [DIV_STAGES];
   logic [32:0] dn_ff [DIV_STAGES];
   side_type    dvs_ff [DIV_STAGES];

   always_ff @(posedge clock) begin
      dv_type      a, b, c, d;
      logic [52:0] rxi, rzi;
      logic [19:0] qxi, qzi;
      logic [32:0] dni;
      if (adv) begin
         for (int k = 0; k < DIV_STAGES; k++) begin
            rxi = (k == 0) ? nx22_ff  : rx_ff[k-1];
            rzi = (k == 0) ? nz22_ff  : rz_ff[k-1];
            qxi = (k == 0) ? 20'd0    : qx_ff[k-1];
            qzi = (k == 0) ? 20'd0    : qz_ff[k-1];
            dni = (k == 0) ? den22_ff : dn_ff[k-1];
            a = dv_step(rxi, dni, 19 - 2 * k);
            b = dv_step(a.rem, dni, 18 - 2 * k);
            c = dv_step(rzi, dni, 19 - 2 * k);
            d = dv_step(c.rem, dni, 18 - 2 * k);
            qxi[19 - 2 * k] = a.qbit;
            qxi[18 - 2 * k] = b.qbit;
            qzi[19 - 2 * k] = c.qbit;
            qzi[18 - 2 * k] = d.qbit;
            rx_ff[k]  <= b.rem;
            rz_ff[k]  <= d.rem;
            qx_ff[k]  <= qxi;
            qz_ff[k]  <= qzi;
            dn_ff[k]  <= dni;
            dvs_ff[k] <= (k == 0) ? side22_ff : dvs_ff[k-1];
         end
      end
   end

   // signs and the camera-above case
   logic signed [20:0] ox_ff, oz_ff;
   logic signed [20:0] qxs_c, qzs_c;
   side_type           sl_c;

   assign qxs_c = $signed({1'b0, qx_ff[DIV_STAGES-1]});
   assign qzs_c = $signed({1'b0, qz_ff[DIV_STAGES-1]});
   assign sl_c  = dvs_ff[DIV_STAGES-1];

   always_ff @(posedge clock) begin
      if (adv) begin
         ox_ff <= sl_c.zero ? 21'sd0 : (sl_c.tzn ? -qxs_c : qxs_c);
         oz_ff <= sl_c.zero ? 21'sd0 : (sl_c.txp ? -qzs_c : qzs_c);
      end
   end

   assign ox = ox_ff;
   assign oz = oz_ff;
endmodule

@@ rtl/core/rlbe_light.sv @@
// Light cone test with exact squared compare.
`timescale 1ns / 1ps
module rlbe_light import rlbe_pkg::*; (
   input  logic        clock,
   input  logic        adv,
   input  logic [31:0] viewer_x,
   input  logic [31:0] viewer_z,
   input  logic [15:0] light_dir_x,
   input  logic [15:0] light_dir_z,
   input  logic [31:0] top_x,
   input  logic [31:0] top_z,
   output logic        lit
);
   logic signed [32:0] dx1_ff, dz1_ff;
   logic signed [48:0] prx2_ff, prz2_ff;
   logic [32:0]        adx2_ff, adz2_ff;
   logic signed [49:0] dot3_ff;
   logic [65:0]        sqx3_ff, sqz3_ff;
   logic               pos4_ff, pos5_ff, pos6_ff;
   logic [48:0]        dm4_ff;
   logic [66:0]        rhs4_ff, rhs5_ff, rhs6_ff;
   logic [49:0]        hh5_ff;
   logic [48:0]        hl5_ff;
   logic [47:0]        ll5_ff;
   logic [98:0]        lhs6_ff;
   logic               lit7_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         dx1_ff  <= $signed({top_x[31], top_x}) - $signed({viewer_x[31], viewer_x});
         dz1_ff  <= $signed({top_z[31], top_z}) - $signed({viewer_z[31], viewer_z});
         prx2_ff <= $signed(light_dir_x) * dx1_ff;
         prz2_ff <= $signed(light_dir_z) * dz1_ff;
         adx2_ff <= dx1_ff[32] ? 33'(-dx1_ff) : 33'(dx1_ff);
         adz2_ff <= dz1_ff[32] ? 33'(-dz1_ff) : 33'(dz1_ff);
         dot3_ff <= 50'(prx2_ff) + 50'(prz2_ff);
         sqx3_ff <= adx2_ff * adx2_ff;
         sqz3_ff <= adz2_ff * adz2_ff;
         pos4_ff <= !dot3_ff[49] && (dot3_ff != 50'sd0);
         dm4_ff  <= dot3_ff[48:0];
         rhs4_ff <= {1'b0, sqx3_ff} + {1'b0, sqz3_ff};
         // split the dot product so each multiply stays narrow
         hh5_ff  <= dm4_ff[48:24] * dm4_ff[48:24];
         hl5_ff  <= dm4_ff[48:24] * dm4_ff[23:0];
         ll5_ff  <= dm4_ff[23:0] * dm4_ff[23:0];
         pos5_ff <= pos4_ff;
         rhs5_ff <= rhs4_ff;
         lhs6_ff <= ({49'd0, hh5_ff} << 49) + ({50'd0, hl5_ff} << 26)
                    + ({51'd0, ll5_ff} << 1);
         pos6_ff <= pos5_ff;
         rhs6_ff <= rhs5_ff;
         lit7_ff <= pos6_ff && (lhs6_ff >= ({32'd0, rhs6_ff} << 28));
      end
   end

   assign lit = lit7_ff;
endmodule

@@ rtl/core/rlbe_shoulder.sv @@
// Shoulder height: 0.97 of the line height, magnitude rounded half up.
`timescale 1ns / 1ps
module rlbe_shoulder import rlbe_pkg::*; (
   input  logic               clock,
   input  logic               adv,
   input  logic [31:0]        top_y,
   input  logic [31:0]        bottom_y,
   output logic signed [33:0] sh
);
   logic signed [32:0] dy1_ff;
   logic [32:0]        mag2_ff;
   logic               neg2_ff, neg3_ff;
   logic [48:0]        prod3_ff;
   logic [32:0]        rmag_c;
   logic signed [33:0] sh4_ff;

   assign rmag_c = 33'((prod3_ff + 49'd32768) >> 16);

   always_ff @(posedge clock) begin
      if (adv) begin
         dy1_ff   <= $signed({bottom_y[31], bottom_y}) - $signed({top_y[31], top_y});
         mag2_ff  <= dy1_ff[32] ? 33'(-dy1_ff) : 33'(dy1_ff);
         neg2_ff  <= dy1_ff[32];
         prod3_ff <= mag2_ff * SHOULDER_Q16;
         neg3_ff  <= neg2_ff;
         sh4_ff   <= neg3_ff ? -$signed({1'b0, rmag_c}) : $signed({1'b0, rmag_c});
      end
   end

   assign sh = sh4_ff;
endmodule

@@ rtl/core/rlbe_emit.sv @@
// Builds the four quad corners and sends them as six vertices.
`timescale 1ns / 1ps
module rlbe_emit import rlbe_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        load,
   output logic        can_load,
   input  emit_in_type ein,
   input  logic [1:0]  color_mode,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_vertex_x,
   output logic [31:0] rsp_vertex_y,
   output logic [31:0] rsp_vertex_z,
   output logic [31:0] rsp_vertex_color,
   output logic        rsp_last_of_line,
   output logic        rsp_last_of_batch
);
   logic        busy_ff;
   logic [2:0]  cnt_ff;
   logic [31:0] px_ff, py_ff, pz_ff, qx_ff, qy_ff, qz_ff;
   logic [31:0] v0x_ff, v2x_ff, vsy_ff, v0z_ff, v2z_ff;
   logic [31:0] c0_ff, c1_ff, c3_ff;
   logic        fin_ff;
   logic [31:0] c0_c, c1_c, c3_c;
   logic signed [33:0] px_s, py_s, pz_s;
   logic        last_beat;

   assign last_beat = (cnt_ff == 3'd5);
   assign can_load  = !busy_ff || (rsp_ready && last_beat);

   assign px_s = $signed({{2{ein.line.top_x[31]}}, ein.line.top_x});
   assign py_s = $signed({{2{ein.line.top_y[31]}}, ein.line.top_y});
   assign pz_s = $signed({{2{ein.line.top_z[31]}}, ein.line.top_z});

   always_comb begin
      c0_c = ein.line.bottom_color;
      c1_c = ein.line.top_color;
      c3_c = ein.line.bottom_color;
      if (color_mode == MODE_LIGHT && ein.lit) begin
         c0_c = (c0_c & RGB_MASK) | ALPHA_FULL;
         c1_c = (c1_c & RGB_MASK) | ALPHA_FULL;
         c3_c = (c3_c & RGB_MASK) | ALPHA_FULL;
      end else if (color_mode == MODE_DEBUG) begin
         c0_c = ein.lit ? LIT_GREEN : UNLIT_RED;
         c1_c = c0_c;
         c3_c = c0_c;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= 3'd0;
      end else if (load) begin
         busy_ff <= 1'b1;
         cnt_ff  <= 3'd0;
      end else if (busy_ff && rsp_ready) begin
         busy_ff <= !last_beat;
         cnt_ff  <= cnt_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         px_ff  <= ein.line.top_x;
         py_ff  <= ein.line.top_y;
         pz_ff  <= ein.line.top_z;
         qx_ff  <= ein.line.bottom_x;
         qy_ff  <= ein.line.bottom_y;
         qz_ff  <= ein.line.bottom_z;
         v0x_ff <= sat32(px_s - 34'(ein.ox));
         v2x_ff <= sat32(px_s + 34'(ein.ox));
         vsy_ff <= sat32(py_s + ein.sh);
         v0z_ff <= sat32(pz_s - 34'(ein.oz));
         v2z_ff <= sat32(pz_s + 34'(ein.oz));
         c0_ff  <= c0_c;
         c1_ff  <= c1_c;
         c3_ff  <= c3_c;
         fin_ff <= ein.line.final_line;
      end
   end

   // triangle order v0 v1 v2, v0 v2 v3
   always_comb begin
      case (cnt_ff)
         3'd0, 3'd3: begin
            rsp_vertex_x = v0x_ff; rsp_vertex_y = vsy_ff; rsp_vertex_z = v0z_ff;
            rsp_vertex_color = c0_ff;
         end
         3'd1: begin
            rsp_vertex_x = px_ff; rsp_vertex_y = py_ff; rsp_vertex_z = pz_ff;
            rsp_vertex_color = c1_ff;
         end
         3'd2, 3'd4: begin
            rsp_vertex_x = v2x_ff; rsp_vertex_y = vsy_ff; rsp_vertex_z = v2z_ff;
            rsp_vertex_color = c0_ff;
         end
         default: begin
            rsp_vertex_x = qx_ff; rsp_vertex_y = qy_ff; rsp_vertex_z = qz_ff;
            rsp_vertex_color = c3_ff;
         end
      endcase
   end

   assign rsp_valid         = busy_ff;
   assign rsp_last_of_line  = last_beat;
   assign rsp_last_of_batch = last_beat & fin_ff;
endmodule

@@ rtl/core/rain_line_billboard_expander.sv @@
// Top level of the rain line billboard expander.
//
//   channel   direction  handshake                  content
//   req_      in         req_valid / req_ready      one rain line, two vertices
//   rsp_      out        rsp_valid / rsp_ready      one quad vertex
//   csr_      in         csr_valid / csr_ready      register index and data
//
// A line runs through a 33-stage pipeline, then the vertex register sends six
// vertices, one a cycle while rsp_ready is high; the single vertex port sets
// the sustained line rate. The depth is set by the square root (two bits a
// stage) and the two divisions (two quotient bits a stage). Reset clears
// valid bits, the emitter and the registers to their defaults. A stall on
// rsp_ holds the pipeline while its last stage holds a line; empty stages
// still advance. Nothing is dropped or repeated.
`timescale 1ns / 1ps
module rain_line_billboard_expander import rlbe_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_top_x,
   input  logic [31:0] req_top_y,
   input  logic [31:0] req_top_z,
   input  logic [31:0] req_top_color,
   input  logic [31:0] req_bottom_x,
   input  logic [31:0] req_bottom_y,
   input  logic [31:0] req_bottom_z,
   input  logic [31:0] req_bottom_color,
   input  logic        req_final_line,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_vertex_x,
   output logic [31:0] rsp_vertex_y,
   output logic [31:0] rsp_vertex_z,
   output logic [31:0] rsp_vertex_color,
   output logic        rsp_last_of_line,
   output logic        rsp_last_of_batch,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data
);
   // configuration registers
   logic [31:0] viewer_x_ff, viewer_z_ff, camera_x_ff, camera_z_ff;
   logic [15:0] light_x_ff, light_z_ff;
   logic [19:0] drop_width_ff;
   logic [1:0]  color_mode_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         viewer_x_ff   <= 32'd0;
         viewer_z_ff   <= 32'd0;
         camera_x_ff   <= 32'd0;
         camera_z_ff   <= 32'd0;
         light_x_ff    <= 16'd16384;
         light_z_ff    <= 16'd0;
         drop_width_ff <= 20'd4096;
         color_mode_ff <= MODE_PASS;
      end else if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_VIEWER_X:   viewer_x_ff   <= csr_data;
            CSR_VIEWER_Z:   viewer_z_ff   <= csr_data;
            CSR_CAMERA_X:   camera_x_ff   <= csr_data;
            CSR_CAMERA_Z:   camera_z_ff   <= csr_data;
            CSR_LIGHT_X:    light_x_ff    <= csr_data[15:0];
            CSR_LIGHT_Z:    light_z_ff    <= csr_data[15:0];
            CSR_DROP_WIDTH: drop_width_ff <= csr_data[19:0];
            CSR_COLOR_MODE: color_mode_ff <= csr_data[1:0];
            default: ;
         endcase
      end
   end

   // pipeline control: advance whenever the last stage is empty or drains
   logic [OFF_LAT-1:0] vld_ff;
   logic               adv, can_load, load;

   assign adv       = !vld_ff[OFF_LAT-1] || can_load;
   assign load      = vld_ff[OFF_LAT-1] && can_load;
   assign req_ready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[OFF_LAT-2:0], req_valid};
      end
   end

   payload_type line_in, line_out;
   assign line_in = '{top_x: req_top_x, top_y: req_top_y, top_z: req_top_z,
                      top_color: req_top_color, bottom_x: req_bottom_x,
                      bottom_y: req_bottom_y, bottom_z: req_bottom_z,
                      bottom_color: req_bottom_color, final_line: req_final_line};

   rlbe_delay #(.WIDTH($bits(payload_type)), .DEPTH(OFF_LAT)) u_line_dly (
      .clock(clock), .adv(adv), .d(line_in), .q(line_out)
   );

   logic signed [20:0] ox, oz;
   rlbe_offset u_offset (
      .clock(clock), .adv(adv), .camera_x(camera_x_ff), .camera_z(camera_z_ff),
      .drop_width(drop_width_ff), .top_x(req_top_x), .top_z(req_top_z),
      .ox(ox), .oz(oz)
   );

   logic lit_early, lit_late;
   rlbe_light u_light (
      .clock(clock), .adv(adv), .viewer_x(viewer_x_ff), .viewer_z(viewer_z_ff),
      .light_dir_x(light_x_ff), .light_dir_z(light_z_ff),
      .top_x(req_top_x), .top_z(req_top_z), .lit(lit_early)
   );
   rlbe_delay #(.WIDTH(1), .DEPTH(OFF_LAT - LIT_LAT)) u_lit_dly (
      .clock(clock), .adv(adv), .d(lit_early), .q(lit_late)
   );

   logic signed [33:0] sh_early, sh_late;
   rlbe_shoulder u_shoulder (
      .clock(clock), .adv(adv), .top_y(req_top_y), .bottom_y(req_bottom_y),
      .sh(sh_early)
   );
   rlbe_delay #(.WIDTH(34), .DEPTH(OFF_LAT - SH_LAT)) u_sh_dly (
      .clock(clock), .adv(adv), .d(sh_early), .q(sh_late)
   );

   emit_in_type ein;
   assign ein = '{line: line_out, ox: ox, oz: oz, sh: sh_late, lit: lit_late};

   rlbe_emit u_emit (
      .clock(clock), .reset(reset), .load(load), .can_load(can_load),
      .ein(ein), .color_mode(color_mode_ff),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_vertex_x(rsp_vertex_x), .rsp_vertex_y(rsp_vertex_y),
      .rsp_vertex_z(rsp_vertex_z), .rsp_vertex_color(rsp_vertex_color),
      .rsp_last_of_line(rsp_last_of_line), .rsp_last_of_batch(rsp_last_of_batch)
   );
endmodule

@@ rtl/core/rlbe_checker.sv @@
// Port-level checks on the vertex channel, bound to the top level.
`timescale 1ns / 1ps
module rlbe_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_vertex_x,
   input logic [31:0] rsp_vertex_color,
   input logic        rsp_last_of_line,
   input logic        rsp_last_of_batch
);
   logic [2:0] beat_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         beat_ff <= 3'd0;
      end else if (rsp_valid && rsp_ready) begin
         beat_ff <= rsp_last_of_line ? 3'd0 : beat_ff + 3'd1;
      end
   end

   a_batch_on_line: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_of_batch |-> rsp_last_of_line)
      else $error("batch end flagged off the sixth vertex");

   a_six_beats: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_last_of_line != (beat_ff == 3'd5)) |-> 1'b0)
      else $error("line end not on the sixth vertex");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_vertex_x)
                                  && $stable(rsp_vertex_color))
      else $error("stalled vertex changed");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("vertex valid after reset");
endmodule

bind rain_line_billboard_expander rlbe_checker u_rlbe_checker (
   .clock(clock), .reset(reset), .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
   .rsp_vertex_x(rsp_vertex_x), .rsp_vertex_color(rsp_vertex_color),
   .rsp_last_of_line(rsp_last_of_line), .rsp_last_of_batch(rsp_last_of_batch)
);
